[hw/rtl/acenm_pkg.sv]
// Shared types, constants and band tables for the n-of-m electrode mapper.
package acenm_pkg;

  localparam int unsigned NUM_BANDS_DEF = 22;
  localparam int unsigned BIN_WIDTH_DEF = 16;
  localparam int unsigned TABLE_BANDS   = 22;
  localparam int unsigned MAX_PICKS     = 22;

  localparam int unsigned POWER_W    = 40;
  localparam int unsigned ENV_W      = 20;
  localparam int unsigned COEFF_W    = 16;
  localparam int unsigned LOG_XW     = 27;
  localparam int unsigned LOG_FRAC   = 16;
  localparam int unsigned LOG_W      = 20;
  localparam int unsigned DIV_NW     = 46;
  localparam int unsigned DIV_DW     = 20;
  localparam int unsigned SLOT_W     = 5;
  localparam int unsigned ELEC_W     = 5;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned LVL8_W     = 8;
  localparam int unsigned WEIGHT_W   = 8;
  localparam int unsigned BINCNT_W   = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 22;
  localparam int unsigned V_W        = 17;

  localparam logic [V_W-1:0]      V_FULL      = 17'h10000;
  localparam logic [LEVEL_W-1:0]  LEVEL_RESET = 16'hA060;
  localparam logic [BINCNT_W-1:0] BINCNT_MAX  = 7'd127;

  localparam logic [BINCNT_W-1:0] BAND_EDGE [TABLE_BANDS+1] = '{
    7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd9, 7'd10, 7'd11, 7'd13, 7'd15,
    7'd17, 7'd19, 7'd22, 7'd25, 7'd29, 7'd33, 7'd38, 7'd43, 7'd49, 7'd56, 7'd64};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_COUNT   = 3'd0,
    REG_COMPRESS_COEFF = 3'd1,
    REG_BASE_ENV       = 3'd2,
    REG_SAT_ENV        = 3'd3,
    REG_DISABLED_MASK  = 3'd4,
    REG_ORDER_MODE     = 3'd5,
    REG_LEVEL_ENTRY    = 3'd6
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQUARE, ST_WEIGHT, ST_ACCUM,
    ST_ROOT_START, ST_ROOT_WAIT,
    ST_PICK_INIT, ST_PICK_SCAN, ST_PICK_MARK,
    ST_EMIT_INIT, ST_EMIT_CHECK, ST_GROW_CLASS, ST_GROW_MUL,
    ST_DIV_START, ST_DIV_WAIT, ST_LOGA_START, ST_LOGA_WAIT,
    ST_LOGB_START, ST_LOGB_WAIT, ST_RATIO_START, ST_RATIO_WAIT,
    ST_LEVEL_MUL, ST_LEVEL_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic load_bin;
    logic square;
    logic weight;
    logic accum;
    logic band_clr;
    logic band_inc;
    logic root_start;
    logic env_write;
    logic pick_clr;
    logic pick_cmp;
    logic pick_mark;
    logic emit_clr;
    logic grow_load;
    logic v_zero;
    logic v_full;
    logic num_mul;
    logic div_start;
    logic div_sel;
    logic take_a;
    logic log_start;
    logic log_sel;
    logic take_la;
    logic take_lb;
    logic take_v;
    logic level_mul;
    logic out_load;
  } acenm_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic root_busy;
    logic band_last;
    logic k_last;
    logic emit_picked;
    logic env_low;
    logic env_high;
    logic div_busy;
    logic log_busy;
    logic lb_zero;
    logic out_free;
  } acenm_status_t;

  // {valid, band index} of a bin position
  function automatic logic [5:0] band_of(input logic [BINCNT_W-1:0] bin);
    logic [5:0] res;
    res = '0;
    for (int m = 0; m < TABLE_BANDS; m++) begin
      if (bin >= BAND_EDGE[m] && bin < BAND_EDGE[m+1]) begin
        res = {1'b1, 5'(m)};
      end
    end
    return res;
  endfunction

  function automatic logic [WEIGHT_W-1:0] band_weight(input logic [4:0] band);
    logic [WEIGHT_W-1:0] w;
    if (band < 5'd9) begin
      w = 8'd251;
    end else if (band < 5'd13) begin
      w = 8'd174;
    end else begin
      w = 8'd166;
    end
    return w;
  endfunction

endpackage

[hw/rtl/acenm_bin_if.sv]
// Input channel: one FFT bin per transaction.
interface acenm_bin_if import acenm_pkg::*; #(
  parameter int unsigned BIN_WIDTH = BIN_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [BIN_WIDTH-1:0] bin_re;
  logic signed [BIN_WIDTH-1:0] bin_im;
  logic                        frame_end;

  modport source (output valid, bin_re, bin_im, frame_end, input ready);
  modport sink (input valid, bin_re, bin_im, frame_end, output ready);
endinterface

[hw/rtl/acenm_stim_if.sv]
// Output channel: one stimulation result per transaction.
interface acenm_stim_if import acenm_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  slot;
  logic [ELEC_W-1:0]  electrode;
  logic [LEVEL_W-1:0] current_level;
  logic               last;

  modport source (output valid, slot, electrode, current_level, last, input ready);
  modport sink (input valid, slot, electrode, current_level, last, output ready);
endinterface

[hw/rtl/acenm_div.sv]
// Restoring divider, one quotient bit per cycle.
module acenm_div import acenm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] dividend_i,
  input  logic [DIV_DW-1:0] divisor_i,
  output logic              busy_o,
  output logic [DIV_NW-1:0] quot_o
);
  localparam int unsigned CNT_W = $clog2(DIV_NW);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIV_DW-1:0] dvs_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem_q, quo_q[DIV_NW-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DIV_NW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? DIV_DW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DIV_DW-1:0];
      quo_q <= {quo_q[DIV_NW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
endmodule

[hw/rtl/acenm_log.sv]
// Base-two logarithm in Q16: normalise, then one fraction bit per squaring.
module acenm_log import acenm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [LOG_XW-1:0] x_i,
  output logic              busy_o,
  output logic [LOG_W-1:0]  log_o
);
  localparam int unsigned M_W   = 31;
  localparam int unsigned EXP_W = 5;

  logic                busy_q;
  logic                norm_q;
  logic [3:0]          rnd_q;
  logic [M_W-1:0]      m_q;
  logic [EXP_W-1:0]    e_q;
  logic [LOG_FRAC-1:0] f_q;
  logic [2*M_W-1:0]    sq;
  logic [M_W:0]        t;
  logic [EXP_W-1:0]    e_int;

  assign sq    = (2*M_W)'(m_q) * (2*M_W)'(m_q);
  assign t     = sq[2*M_W-1:M_W-1];
  assign e_int = e_q - EXP_W'(LOG_FRAC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      norm_q <= 1'b0;
      rnd_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      norm_q <= 1'b1;
      rnd_q  <= '0;
    end else if (busy_q) begin
      if (norm_q) begin
        if (m_q[M_W-1]) begin
          norm_q <= 1'b0;
        end
      end else begin
        rnd_q <= rnd_q + 4'd1;
        if (rnd_q == 4'd15) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q <= {x_i, 4'b0};
      e_q <= EXP_W'(LOG_XW - 1);
      f_q <= '0;
    end else if (busy_q) begin
      if (norm_q) begin
        if (!m_q[M_W-1]) begin
          m_q <= {m_q[M_W-2:0], 1'b0};
          e_q <= e_q - EXP_W'(1);
        end
      end else begin
        m_q <= t[M_W] ? t[M_W:1] : t[M_W-1:0];
        f_q <= {f_q[LOG_FRAC-2:0], t[M_W]};
      end
    end
  end

  assign busy_o = busy_q;
  assign log_o  = {e_int[3:0], f_q};
endmodule

[hw/rtl/acenm_dp.sv]
// Datapath: band power, envelope root, pick, loudness growth and output register.
module acenm_dp import acenm_pkg::*; #(
  parameter int unsigned NUM_BANDS = NUM_BANDS_DEF,
  parameter int unsigned BIN_WIDTH = BIN_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  acenm_cmd_t                  cmd_i,
  output acenm_status_t               status_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic signed [BIN_WIDTH-1:0] bin_re_i,
  input  logic signed [BIN_WIDTH-1:0] bin_im_i,
  input  logic                        frame_end_i,
  input  logic                        stim_ready_i,
  output logic                        stim_valid_o,
  output logic [SLOT_W-1:0]           slot_o,
  output logic [ELEC_W-1:0]           electrode_o,
  output logic [LEVEL_W-1:0]          current_level_o,
  output logic                        last_o
);
  localparam int unsigned BIDX_W = $clog2(NUM_BANDS);
  localparam int unsigned PW     = 2 * BIN_WIDTH;
  localparam int unsigned SW     = ((PW > POWER_W) ? PW : POWER_W) + 1;
  localparam int unsigned MAXN   = (NUM_BANDS < MAX_PICKS) ? NUM_BANDS : MAX_PICKS;
  localparam int unsigned RW     = POWER_W + 1;
  localparam int unsigned LP_W   = 2 * LVL8_W + V_W;
  localparam logic [BIDX_W-1:0] BAND_LAST = BIDX_W'(NUM_BANDS - 1);

  // configuration
  logic [SLOT_W-1:0]    act_q;
  logic [COEFF_W-1:0]   coeff_q;
  logic [ENV_W-1:0]     base_q;
  logic [ENV_W-1:0]     sat_q;
  logic [TABLE_BANDS-1:0] mask_q;
  logic                 order_q;
  logic [LEVEL_W-1:0]   lvl_q [NUM_BANDS];
  logic [4:0]           lvl_e;
  logic                 lvl_ok;

  assign lvl_e  = cfg_data_i[20:16];
  assign lvl_ok = (32'(lvl_e) < NUM_BANDS) && (cfg_data_i[15:8] > cfg_data_i[7:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 5'd8;
      coeff_q <= 16'd26637;
      base_q  <= 20'd23;
      sat_q   <= 20'd2331;
      mask_q  <= '0;
      order_q <= 1'b0;
      for (int i = 0; i < NUM_BANDS; i++) begin
        lvl_q[i] <= LEVEL_RESET;
      end
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ACTIVE_COUNT:   act_q   <= cfg_data_i[SLOT_W-1:0];
        REG_COMPRESS_COEFF: coeff_q <= cfg_data_i[COEFF_W-1:0];
        REG_BASE_ENV:       base_q  <= cfg_data_i[ENV_W-1:0];
        REG_SAT_ENV:        sat_q   <= cfg_data_i[ENV_W-1:0];
        REG_DISABLED_MASK:  mask_q  <= cfg_data_i[TABLE_BANDS-1:0];
        REG_ORDER_MODE:     order_q <= cfg_data_i[0];
        REG_LEVEL_ENTRY: begin
          if (lvl_ok) begin
            lvl_q[lvl_e[BIDX_W-1:0]] <= cfg_data_i[LEVEL_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  logic [NUM_BANDS-1:0] mask_ext;
  always_comb begin
    for (int i = 0; i < NUM_BANDS; i++) begin
      mask_ext[i] = (i < TABLE_BANDS) ? mask_q[i % TABLE_BANDS] : 1'b0;
    end
  end

  // bin accumulation
  logic [BINCNT_W-1:0]          bin_cnt_q;
  logic [5:0]                   band_info;
  logic                         band_ok;
  logic signed [BIN_WIDTH-1:0]  re_q, im_q;
  logic                         fe_q;
  logic                         bok_q;
  logic [BIDX_W-1:0]            bidx_q;
  logic [WEIGHT_W-1:0]          bw_q;
  logic signed [PW-1:0]         prod_re, prod_im;
  logic [PW-1:0]                sqre_q, sqim_q;
  logic [PW-1:0]                psum;
  logic [PW+WEIGHT_W-1:0]       wprod;
  logic [PW-1:0]                wp_q;
  logic [SW-1:0]                acc_sum;
  logic [POWER_W-1:0]           bp_q [NUM_BANDS];
  logic [BIDX_W-1:0]            m_q;

  assign band_info = band_of(bin_cnt_q);
  assign band_ok   = band_info[5] && (32'(band_info[4:0]) < NUM_BANDS);
  assign prod_re   = re_q * re_q;
  assign prod_im   = im_q * im_q;
  assign psum      = sqre_q + sqim_q;
  assign wprod     = (PW+WEIGHT_W)'(psum) * (PW+WEIGHT_W)'(bw_q);
  assign acc_sum   = SW'(bp_q[bidx_q]) + SW'(wp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_cnt_q <= '0;
    end else if (cmd_i.load_bin) begin
      if (frame_end_i) begin
        bin_cnt_q <= '0;
      end else if (bin_cnt_q != BINCNT_MAX) begin
        bin_cnt_q <= bin_cnt_q + BINCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_bin) begin
      re_q   <= bin_re_i;
      im_q   <= bin_im_i;
      fe_q   <= frame_end_i;
      bok_q  <= band_ok;
      bidx_q <= band_info[BIDX_W-1:0];
      bw_q   <= band_weight(band_info[4:0]);
    end
    if (cmd_i.square) begin
      sqre_q <= $unsigned(prod_re);
      sqim_q <= $unsigned(prod_im);
    end
    if (cmd_i.weight) begin
      wp_q <= wprod[PW+WEIGHT_W-1:WEIGHT_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        bp_q[i] <= '0;
      end
    end else if (cmd_i.accum && bok_q) begin
      bp_q[bidx_q] <= (acc_sum > SW'({POWER_W{1'b1}})) ? {POWER_W{1'b1}} :
                      acc_sum[POWER_W-1:0];
    end else if (cmd_i.root_start) begin
      bp_q[m_q] <= '0;
    end
  end

  // envelope root, one result bit per cycle
  logic          root_busy_q;
  logic [RW-1:0] rx_q, rr_q, rbit_q;
  logic [RW-1:0] rtrial;

  assign rtrial = rr_q + rbit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_busy_q <= 1'b0;
    end else if (cmd_i.root_start) begin
      root_busy_q <= 1'b1;
    end else if (root_busy_q && rbit_q[0]) begin
      root_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_start) begin
      rx_q   <= RW'(bp_q[m_q]);
      rr_q   <= '0;
      rbit_q <= {1'b1, {POWER_W{1'b0}}};
    end else if (root_busy_q) begin
      if (rx_q >= rtrial) begin
        rx_q <= rx_q - rtrial;
        rr_q <= (rr_q >> 1) + rbit_q;
      end else begin
        rr_q <= rr_q >> 1;
      end
      rbit_q <= rbit_q >> 2;
    end
  end

  // band counter, envelopes and picking
  logic [ENV_W-1:0]     env_q [NUM_BANDS];
  logic [NUM_BANDS-1:0] picked_q;
  logic [BIDX_W-1:0]    best_q;
  logic [ENV_W-1:0]     best_env_q;
  logic                 best_vld_q;
  logic [SLOT_W-1:0]    k_q, n_q, n_d;
  logic                 k_last;
  logic [BIDX_W-1:0]    e_idx;

  assign k_last = (k_q + SLOT_W'(1)) == n_q;
  assign e_idx  = order_q ? m_q : BAND_LAST - m_q;

  always_comb begin
    n_d = (act_q == '0) ? SLOT_W'(1) : act_q;
    if (n_d > SLOT_W'(MAXN)) begin
      n_d = SLOT_W'(MAXN);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q        <= '0;
      picked_q   <= '0;
      best_vld_q <= 1'b0;
      k_q        <= '0;
      n_q        <= SLOT_W'(1);
    end else begin
      if (cmd_i.band_clr) begin
        m_q <= '0;
      end else if (cmd_i.band_inc) begin
        m_q <= m_q + BIDX_W'(1);
      end
      if (cmd_i.pick_clr) begin
        picked_q   <= '0;
        best_vld_q <= 1'b0;
        k_q        <= '0;
        n_q        <= n_d;
      end else if (cmd_i.pick_mark) begin
        picked_q[best_q] <= 1'b1;
        best_vld_q       <= 1'b0;
        k_q              <= k_q + SLOT_W'(1);
      end else if (cmd_i.pick_cmp) begin
        if (!picked_q[m_q] && (!best_vld_q || env_q[m_q] >= best_env_q)) begin
          best_vld_q <= 1'b1;
        end
      end else if (cmd_i.emit_clr) begin
        k_q <= '0;
      end else if (cmd_i.out_load) begin
        k_q <= k_q + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.env_write) begin
      env_q[m_q] <= mask_ext[m_q] ? '0 : rr_q[ENV_W-1:0];
    end
    if (cmd_i.pick_cmp && !picked_q[m_q] &&
        (!best_vld_q || env_q[m_q] >= best_env_q)) begin
      best_q     <= m_q;
      best_env_q <= env_q[m_q];
    end
  end

  // loudness growth and level mapping
  logic [ENV_W-1:0]         cur_env_q;
  logic [BIDX_W-1:0]        cur_e_q;
  logic [LVL8_W-1:0]        thr_q, com_q;
  logic [DIV_NW-1:0]        num_q;
  logic [LOG_XW-1:0]        a_q, b_val;
  logic [LOG_W-1:0]         la_q, lb_q;
  logic [V_W-1:0]           v_q;
  logic [LP_W-1:0]          lvp_q;
  logic [ENV_W-1:0]         d_env, span;
  logic [COEFF_W+ENV_W-1:0] cd;
  logic [LVL8_W-1:0]        diff;
  logic [LP_W:0]            lsum;
  logic [DIV_NW-1:0]        div_dvd, div_quot;
  logic [DIV_DW-1:0]        div_dvs;
  logic                     div_busy;
  logic [LOG_XW-1:0]        log_x;
  logic [LOG_W-1:0]         log_res;
  logic                     log_busy;

  assign d_env   = cur_env_q - base_q;
  assign span    = sat_q - base_q;
  assign cd      = (COEFF_W+ENV_W)'(coeff_q) * (COEFF_W+ENV_W)'(d_env);
  assign b_val   = LOG_XW'(V_FULL) + LOG_XW'({coeff_q, 10'b0});
  assign diff    = com_q - thr_q;
  assign lsum    = (LP_W+1)'(lvp_q) + (LP_W+1)'(32768);
  assign div_dvd = cmd_i.div_sel ? DIV_NW'({la_q, 16'b0}) : num_q;
  assign div_dvs = cmd_i.div_sel ? lb_q : span;
  assign log_x   = cmd_i.log_sel ? b_val : a_q;

  acenm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  acenm_log u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.log_start),
    .x_i     (log_x),
    .busy_o  (log_busy),
    .log_o   (log_res)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.grow_load) begin
      cur_env_q <= env_q[e_idx];
      cur_e_q   <= e_idx;
      thr_q     <= lvl_q[e_idx][LVL8_W-1:0];
      com_q     <= lvl_q[e_idx][LEVEL_W-1:LVL8_W];
    end
    if (cmd_i.num_mul) begin
      num_q <= {cd, 10'b0};
    end
    if (cmd_i.take_a) begin
      a_q <= LOG_XW'(V_FULL) + LOG_XW'(div_quot[LOG_XW-2:0]);
    end
    if (cmd_i.take_la) begin
      la_q <= log_res;
    end
    if (cmd_i.take_lb) begin
      lb_q <= log_res;
    end
    if (cmd_i.v_zero) begin
      v_q <= '0;
    end else if (cmd_i.v_full) begin
      v_q <= V_FULL;
    end else if (cmd_i.take_v) begin
      v_q <= (div_quot > DIV_NW'(V_FULL)) ? V_FULL : div_quot[V_W-1:0];
    end
    if (cmd_i.level_mul) begin
      lvp_q <= LP_W'({diff, 8'b0}) * LP_W'(v_q);
    end
  end

  // output register
  logic                out_valid_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [ELEC_W-1:0]   elec_q;
  logic [LEVEL_W-1:0]  level_q;
  logic                last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (stim_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      slot_q  <= k_q;
      elec_q  <= ELEC_W'(cur_e_q);
      level_q <= {thr_q, 8'b0} + lsum[LEVEL_W+15:16];
      last_q  <= k_last;
    end
  end

  assign stim_valid_o    = out_valid_q;
  assign slot_o          = slot_q;
  assign electrode_o     = elec_q;
  assign current_level_o = level_q;
  assign last_o          = last_q;

  assign status_o.frame_end   = fe_q;
  assign status_o.root_busy   = root_busy_q;
  assign status_o.band_last   = m_q == BAND_LAST;
  assign status_o.k_last      = k_last;
  assign status_o.emit_picked = picked_q[e_idx];
  assign status_o.env_low     = cur_env_q <= base_q;
  assign status_o.env_high    = cur_env_q >= sat_q;
  assign status_o.div_busy    = div_busy;
  assign status_o.log_busy    = log_busy;
  assign status_o.lb_zero     = lb_q == '0;
  assign status_o.out_free    = !out_valid_q || stim_ready_i;
endmodule

[hw/rtl/acenm_ctrl.sv]
// Controller: sequences bin accumulation and the frame-end root, pick and emit passes.
module acenm_ctrl import acenm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          bin_valid_i,
  output logic          bin_ready_o,
  input  acenm_status_t status_i,
  output acenm_cmd_t    cmd_o
);
  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    bin_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        bin_ready_o = 1'b1;
        if (bin_valid_i) begin
          cmd_o.load_bin = 1'b1;
          state_d        = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_WEIGHT;
      end
      ST_WEIGHT: begin
        cmd_o.weight = 1'b1;
        state_d      = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        if (status_i.frame_end) begin
          cmd_o.band_clr = 1'b1;
          state_d        = ST_ROOT_START;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ROOT_START: begin
        cmd_o.root_start = 1'b1;
        state_d          = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (!status_i.root_busy) begin
          cmd_o.env_write = 1'b1;
          if (status_i.band_last) begin
            state_d = ST_PICK_INIT;
          end else begin
            cmd_o.band_inc = 1'b1;
            state_d        = ST_ROOT_START;
          end
        end
      end
      ST_PICK_INIT: begin
        cmd_o.pick_clr = 1'b1;
        cmd_o.band_clr = 1'b1;
        state_d        = ST_PICK_SCAN;
      end
      ST_PICK_SCAN: begin
        cmd_o.pick_cmp = 1'b1;
        if (status_i.band_last) begin
          state_d = ST_PICK_MARK;
        end else begin
          cmd_o.band_inc = 1'b1;
        end
      end
      ST_PICK_MARK: begin
        cmd_o.pick_mark = 1'b1;
        cmd_o.band_clr  = 1'b1;
        state_d         = status_i.k_last ? ST_EMIT_INIT : ST_PICK_SCAN;
      end
      ST_EMIT_INIT: begin
        cmd_o.emit_clr = 1'b1;
        cmd_o.band_clr = 1'b1;
        state_d        = ST_EMIT_CHECK;
      end
      ST_EMIT_CHECK: begin
        if (status_i.emit_picked) begin
          cmd_o.grow_load = 1'b1;
          state_d         = ST_GROW_CLASS;
        end else begin
          cmd_o.band_inc = 1'b1;
        end
      end
      ST_GROW_CLASS: begin
        if (status_i.env_low) begin
          cmd_o.v_zero = 1'b1;
          state_d      = ST_LEVEL_MUL;
        end else if (status_i.env_high) begin
          cmd_o.v_full = 1'b1;
          state_d      = ST_LEVEL_MUL;
        end else begin
          cmd_o.num_mul = 1'b1;
          state_d       = ST_DIV_START;
        end
      end
      ST_GROW_MUL: begin
        state_d = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!status_i.div_busy) begin
          cmd_o.take_a = 1'b1;
          state_d      = ST_LOGA_START;
        end
      end
      ST_LOGA_START: begin
        cmd_o.log_start = 1'b1;
        state_d         = ST_LOGA_WAIT;
      end
      ST_LOGA_WAIT: begin
        if (!status_i.log_busy) begin
          cmd_o.take_la = 1'b1;
          state_d       = ST_LOGB_START;
        end
      end
      ST_LOGB_START: begin
        cmd_o.log_start = 1'b1;
        cmd_o.log_sel   = 1'b1;
        state_d         = ST_LOGB_WAIT;
      end
      ST_LOGB_WAIT: begin
        if (!status_i.log_busy) begin
          cmd_o.take_lb = 1'b1;
          state_d       = ST_RATIO_START;
        end
      end
      ST_RATIO_START: begin
        if (status_i.lb_zero) begin
          cmd_o.v_zero = 1'b1;
          state_d      = ST_LEVEL_MUL;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = 1'b1;
          state_d         = ST_RATIO_WAIT;
        end
      end
      ST_RATIO_WAIT: begin
        if (!status_i.div_busy) begin
          cmd_o.take_v = 1'b1;
          state_d      = ST_LEVEL_MUL;
        end
      end
      ST_LEVEL_MUL: begin
        cmd_o.level_mul = 1'b1;
        state_d         = ST_LEVEL_OUT;
      end
      ST_LEVEL_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (status_i.k_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.band_inc = 1'b1;
            state_d        = ST_EMIT_CHECK;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

[hw/rtl/ace_n_of_m_electrode_mapper.sv]
// Top level of the n-of-m electrode mapper: controller, datapath and channels.
//
//   channel   direction  transaction           payload
//   bin_i     in         one FFT bin           bin_re, bin_im, frame_end
//   stim_o    out        one stimulation pick  slot, electrode, current_level, last
//   cfg       in         one register write    cfg_we_i, cfg_idx_i, cfg_data_i
//
// A bin is accepted, squared, weighted and accumulated into its band, one
// state each, before the next bin is taken. At frame end: a bit-serial root
// per band, n pick scans over the bands, then per pick up to two divisions
// and two logarithms on the shared units. Band sums reset to zero and are
// cleared by the root pass; no clearing pass. A result waits in the output
// register while stim_o stalls; the next bin is taken once the last result
// of the frame is in that register.
module ace_n_of_m_electrode_mapper import acenm_pkg::*; #(
  parameter int unsigned NUM_BANDS = NUM_BANDS_DEF,
  parameter int unsigned BIN_WIDTH = BIN_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  acenm_bin_if.sink             bin_i,
  acenm_stim_if.source          stim_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);
  acenm_cmd_t    cmd;
  acenm_status_t status;
  logic          bin_ready;

  acenm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bin_valid_i (bin_i.valid),
    .bin_ready_o (bin_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  acenm_dp #(
    .NUM_BANDS (NUM_BANDS),
    .BIN_WIDTH (BIN_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .bin_re_i        (bin_i.bin_re),
    .bin_im_i        (bin_i.bin_im),
    .frame_end_i     (bin_i.frame_end),
    .stim_ready_i    (stim_o.ready),
    .stim_valid_o    (stim_o.valid),
    .slot_o          (stim_o.slot),
    .electrode_o     (stim_o.electrode),
    .current_level_o (stim_o.current_level),
    .last_o          (stim_o.last)
  );

  assign bin_i.ready = bin_ready;
endmodule
